FILE: hdl/rmva_pkg.sv
`timescale 1ns / 1ps

package rmva_pkg;

    // Field widths of the item and of the held summary.
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 32;
    localparam int M2_W    = 63;

    // Derived widths of the working values.
    localparam int DIFF_W = DATA_W + 1;
    localparam int N_W    = COUNT_W + 1;
    localparam int MB_W   = (DIFF_W > N_W) ? DIFF_W : N_W;
    localparam int MA_W   = (M2_W > MB_W) ? M2_W : MB_W;
    localparam int PROD_W = MA_W + MB_W;

    // Datapath operations, one per command cycle.
    typedef enum logic [4:0] {
        OP_NOP,
        OP_FIRST,
        OP_LOAD_WA,
        OP_LOAD_WS,
        OP_LOAD_G,
        OP_W_MEAN,
        OP_W_EMAG,
        OP_W_ADD,
        OP_W_COMMIT,
        OP_G_MEAN,
        OP_G_QR,
        OP_G_A,
        OP_TERM_ZERO,
        OP_TERM_MAX,
        OP_TERM_Q,
        OP_TERM_ADD,
        OP_G_ADD1,
        OP_G_ADD2,
        OP_PUBLISH
    } op_t;

    // Operand pairs of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_D_E,
        MUL_D_NR,
        MUL_NL_NR,
        MUL_D_D,
        MUL_A_Q,
        MUL_A_R
    } mul_sel_t;

    // Dividend sources of the shared divider.
    typedef enum logic {
        DIV_DMAG,
        DIV_PROD
    } div_sel_t;

    typedef struct packed {
        op_t      op;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     div_start;
        div_sel_t div_sel;
    } cmd_t;

    typedef struct packed {
        logic act;
        logic cnt_zero;
        logic cnt_one;
        logic nr_zero;
        logic nr_one;
        logic qr_zero;
        logic a_big;
        logic mul_done;
        logic div_done;
    } status_t;

    localparam cmd_t CMD_IDLE = '{
        op: OP_NOP, mul_start: 1'b0, mul_sel: MUL_D_E, div_start: 1'b0, div_sel: DIV_DMAG
    };

endpackage

FILE: hdl/rmva_mul.sv
`timescale 1ns / 1ps

module rmva_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rmva_pkg::MA_W-1:0]  a,
    input  logic [rmva_pkg::MB_W-1:0]  b,
    output logic [rmva_pkg::PROD_W-1:0] prod,
    output logic                       done
);
    import rmva_pkg::*;

    localparam int CNT_W = $clog2(MB_W + 1);

    logic [PROD_W-1:0] p_reg;
    logic [MA_W-1:0]   a_reg;
    logic [CNT_W-1:0]  step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [MA_W:0]     sum;

    // One multiplier bit per cycle: add the multiplicand into the upper half, shift right.
    assign sum = {1'b0, p_reg[PROD_W-1:MB_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= CNT_W'(MB_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and product registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            p_reg <= PROD_W'(b);
        end
        else if (busy_reg)
        begin
            p_reg <= {sum, p_reg[MB_W-1:1]};
        end
    end

    assign prod = p_reg;
    assign done = done_reg;

endmodule

FILE: hdl/rmva_div.sv
`timescale 1ns / 1ps

module rmva_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rmva_pkg::PROD_W-1:0] dividend,
    input  logic [rmva_pkg::N_W-1:0]    divisor,
    output logic [rmva_pkg::PROD_W-1:0] quot,
    output logic [rmva_pkg::N_W-1:0]    rem,
    output logic                        done
);
    import rmva_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] q_reg;
    logic [N_W-1:0]    r_reg;
    logic [N_W-1:0]    dvs_reg;
    logic [CNT_W-1:0]  step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [N_W:0]      shifted;
    logic [N_W:0]      diff;
    logic              fits;

    // Restoring division, one quotient bit per cycle.
    assign shifted = {r_reg, q_reg[PROD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= CNT_W'(PROD_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient, remainder and divisor registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            r_reg   <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[PROD_W-2:0], fits};
            r_reg <= fits ? diff[N_W-1:0] : shifted[N_W-1:0];
        end
    end

    assign quot = q_reg;
    assign rem  = r_reg;
    assign done = done_reg;

endmodule

FILE: hdl/rmva_datapath.sv
`timescale 1ns / 1ps

module rmva_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  logic                         action,
    input  logic [rmva_pkg::DATA_W-1:0]  sample,
    input  logic [rmva_pkg::DATA_W-1:0]  part_mean,
    input  logic [rmva_pkg::M2_W-1:0]    part_m2,
    input  logic [rmva_pkg::COUNT_W-1:0] part_count,
    input  rmva_pkg::cmd_t               cmd,
    output rmva_pkg::status_t            status,
    output logic [rmva_pkg::COUNT_W-1:0] total_count,
    output logic [rmva_pkg::DATA_W-1:0]  running_mean,
    output logic [rmva_pkg::M2_W-1:0]    running_m2,
    output logic                         overflow
);
    import rmva_pkg::*;

    localparam logic [M2_W-1:0] M2_MAX = '1;

    // Captured item.
    logic               act_reg;
    logic [DATA_W-1:0]  samp_reg;
    logic [DATA_W-1:0]  pm_reg;
    logic [M2_W-1:0]    pm2_reg;
    logic [COUNT_W-1:0] nr_reg;

    // Held summary.
    logic [COUNT_W-1:0] cnt_reg;
    logic [DATA_W-1:0]  mean_reg;
    logic [M2_W-1:0]    m2_reg;
    logic               ovf_reg;

    // Working values.
    logic [DATA_W-1:0]  wm_reg;
    logic [M2_W-1:0]    wm2_reg;
    logic [DATA_W-1:0]  wx_reg;
    logic [N_W-1:0]     n_reg;
    logic [DIFF_W-1:0]  dmag_reg;
    logic               dneg_reg;
    logic [DIFF_W-1:0]  emag_reg;
    logic [N_W-1:0]     qn_reg;
    logic [N_W-1:0]     rn_reg;
    logic [M2_W-1:0]    a_reg;
    logic [M2_W-1:0]    term_reg;

    // Result registers.
    logic [COUNT_W-1:0] out_cnt_reg;
    logic [DATA_W-1:0]  out_mean_reg;
    logic [M2_W-1:0]    out_m2_reg;
    logic               out_ovf_reg;

    // Shared units.
    logic [MA_W-1:0]    mul_a;
    logic [MB_W-1:0]    mul_b;
    logic [PROD_W-1:0]  prod;
    logic               mul_done;
    logic [PROD_W-1:0]  div_in;
    logic [PROD_W-1:0]  quot;
    logic [N_W-1:0]     rem;
    logic               div_done;

    // Combinational helpers.
    logic [DATA_W-1:0]  xval;
    logic [DATA_W-1:0]  sub_a;
    logic [DATA_W-1:0]  sub_b;
    logic [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]  diff_mag;
    logic [N_W-1:0]     n_sum;
    logic [DATA_W-1:0]  adj_base;
    logic [DIFF_W-1:0]  adj;
    logic [DIFF_W-1:0]  e_diff;
    logic [DIFF_W-1:0]  e_mag;
    logic               prod_big;
    logic [M2_W-1:0]    prod_sat;
    logic [M2_W:0]      w_add;
    logic [M2_W:0]      t_add;
    logic [M2_W:0]      g_add1;
    logic [M2_W:0]      g_add2;
    logic               n_big;
    logic [COUNT_W-1:0] n_sat;

    function automatic logic [M2_W:0] sat_add(input logic [M2_W-1:0] x, input logic [M2_W-1:0] y);
        logic [M2_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s[M2_W])
        begin
            return {1'b1, M2_MAX};
        end
        return {1'b0, s[M2_W-1:0]};
    endfunction

    // Multiplier operand selection.
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_D_E:   begin mul_a = MA_W'(dmag_reg); mul_b = MB_W'(emag_reg); end
            MUL_D_NR:  begin mul_a = MA_W'(dmag_reg); mul_b = MB_W'(nr_reg);   end
            MUL_NL_NR: begin mul_a = MA_W'(cnt_reg);  mul_b = MB_W'(nr_reg);   end
            MUL_D_D:   begin mul_a = MA_W'(dmag_reg); mul_b = MB_W'(dmag_reg); end
            MUL_A_Q:   begin mul_a = MA_W'(a_reg);    mul_b = MB_W'(qn_reg);   end
            MUL_A_R:   begin mul_a = MA_W'(a_reg);    mul_b = MB_W'(rn_reg);   end
            default:   begin mul_a = '0;              mul_b = '0;              end
        endcase
    end

    assign div_in = (cmd.div_sel == DIV_PROD) ? prod : PROD_W'(dmag_reg);

    rmva_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (prod),
        .done  (mul_done)
    );

    rmva_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_in),
        .divisor  (n_reg),
        .quot     (quot),
        .rem      (rem),
        .done     (div_done)
    );

    // Deviation of the incoming mean or sample from the held mean.
    assign xval  = act_reg ? pm_reg : samp_reg;
    assign sub_a = (cmd.op == OP_LOAD_WS) ? mean_reg : xval;
    assign sub_b = (cmd.op == OP_LOAD_WS) ? pm_reg : mean_reg;
    assign diff  = {sub_a[DATA_W-1], sub_a} - {sub_b[DATA_W-1], sub_b};
    assign diff_mag = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;

    // Exact new count for each case.
    assign n_sum = {1'b0, (cmd.op == OP_LOAD_WS) ? nr_reg : cnt_reg}
                 + ((cmd.op == OP_LOAD_G) ? {1'b0, nr_reg} : N_W'(1));

    // Mean moves toward the new value by the truncated quotient.
    assign adj_base = (cmd.op == OP_G_MEAN) ? mean_reg : wm_reg;
    assign adj = dneg_reg ? ({adj_base[DATA_W-1], adj_base} - quot[DIFF_W-1:0])
                          : ({adj_base[DATA_W-1], adj_base} + quot[DIFF_W-1:0]);

    // Deviation from the updated mean.
    assign e_diff = {wx_reg[DATA_W-1], wx_reg} - {wm_reg[DATA_W-1], wm_reg};
    assign e_mag  = e_diff[DIFF_W-1] ? (~e_diff + 1'b1) : e_diff;

    // Clamp of a product to the M2 range.
    assign prod_big = |prod[PROD_W-1:M2_W];
    assign prod_sat = prod_big ? M2_MAX : prod[M2_W-1:0];

    assign w_add  = sat_add(wm2_reg, prod_sat);
    assign t_add  = sat_add(term_reg, quot[M2_W-1:0]);
    assign g_add1 = sat_add(m2_reg, pm2_reg);
    assign g_add2 = sat_add(m2_reg, term_reg);

    // Stored count saturates.
    assign n_big = |n_reg[N_W-1:COUNT_W];
    assign n_sat = n_big ? '1 : n_reg[COUNT_W-1:0];

    // Held summary and overflow flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            mean_reg <= '0;
            m2_reg   <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                OP_FIRST:
                begin
                    cnt_reg  <= cnt_reg + 1'b1;
                    mean_reg <= xval;
                    m2_reg   <= '0;
                end
                OP_W_ADD:
                begin
                    ovf_reg <= ovf_reg | prod_big | w_add[M2_W];
                end
                OP_W_COMMIT:
                begin
                    cnt_reg  <= n_sat;
                    mean_reg <= wm_reg;
                    m2_reg   <= wm2_reg;
                    ovf_reg  <= ovf_reg | n_big;
                end
                OP_G_MEAN:
                begin
                    mean_reg <= adj[DATA_W-1:0];
                end
                OP_TERM_MAX:
                begin
                    ovf_reg <= 1'b1;
                end
                OP_TERM_Q:
                begin
                    ovf_reg <= ovf_reg | prod_big;
                end
                OP_TERM_ADD:
                begin
                    ovf_reg <= ovf_reg | t_add[M2_W];
                end
                OP_G_ADD1:
                begin
                    m2_reg  <= g_add1[M2_W-1:0];
                    ovf_reg <= ovf_reg | g_add1[M2_W];
                end
                OP_G_ADD2:
                begin
                    m2_reg  <= g_add2[M2_W-1:0];
                    cnt_reg <= n_sat;
                    ovf_reg <= ovf_reg | g_add2[M2_W] | n_big;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Captured item and working values.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            act_reg  <= action;
            samp_reg <= sample;
            pm_reg   <= part_mean;
            pm2_reg  <= part_m2;
            nr_reg   <= part_count;
        end
        unique case (cmd.op)
            OP_LOAD_WA:
            begin
                wm_reg   <= mean_reg;
                wm2_reg  <= m2_reg;
                wx_reg   <= xval;
                n_reg    <= n_sum;
                dmag_reg <= diff_mag;
                dneg_reg <= diff[DIFF_W-1];
            end
            OP_LOAD_WS:
            begin
                wm_reg   <= pm_reg;
                wm2_reg  <= pm2_reg;
                wx_reg   <= mean_reg;
                n_reg    <= n_sum;
                dmag_reg <= diff_mag;
                dneg_reg <= diff[DIFF_W-1];
            end
            OP_LOAD_G:
            begin
                n_reg    <= n_sum;
                dmag_reg <= diff_mag;
                dneg_reg <= diff[DIFF_W-1];
            end
            OP_W_MEAN:    wm_reg   <= adj[DATA_W-1:0];
            OP_W_EMAG:    emag_reg <= e_mag;
            OP_W_ADD:     wm2_reg  <= w_add[M2_W-1:0];
            OP_G_QR:
            begin
                qn_reg <= quot[N_W-1:0];
                rn_reg <= rem;
            end
            OP_G_A:       a_reg    <= prod[M2_W-1:0];
            OP_TERM_ZERO: term_reg <= '0;
            OP_TERM_MAX:  term_reg <= M2_MAX;
            OP_TERM_Q:    term_reg <= prod_sat;
            OP_TERM_ADD:  term_reg <= t_add[M2_W-1:0];
            OP_PUBLISH:
            begin
                out_cnt_reg  <= cnt_reg;
                out_mean_reg <= mean_reg;
                out_m2_reg   <= m2_reg;
                out_ovf_reg  <= ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Status toward the controller.
    always_comb
    begin
        status.act      = act_reg;
        status.cnt_zero = (cnt_reg == '0);
        status.cnt_one  = (cnt_reg == COUNT_W'(1));
        status.nr_zero  = (nr_reg == '0);
        status.nr_one   = (nr_reg == COUNT_W'(1));
        status.qr_zero  = (qn_reg == '0) && (rn_reg == '0);
        status.a_big    = prod_big;
        status.mul_done = mul_done;
        status.div_done = div_done;
    end

    assign total_count  = out_cnt_reg;
    assign running_mean = out_mean_reg;
    assign running_m2   = out_m2_reg;
    assign overflow     = out_ovf_reg;

endmodule

FILE: hdl/rmva_ctrl.sv
`timescale 1ns / 1ps

module rmva_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_stall,
    input  rmva_pkg::status_t status,
    output rmva_pkg::cmd_t    cmd,
    output logic              in_stall,
    output logic              out_valid
);
    import rmva_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_W_START,
        S_W_DIV,
        S_W_EMAG,
        S_W_MULS,
        S_W_MUL,
        S_W_COMMIT,
        S_G_M1S,
        S_G_M1,
        S_G_D1,
        S_G_M2,
        S_G_D2,
        S_G_M3,
        S_G_M4S,
        S_G_M4,
        S_G_M5S,
        S_G_M5,
        S_G_D3,
        S_G_ADD1,
        S_G_ADD2,
        S_PUB,
        S_FIN
    } state_t;

    state_t state_reg;
    cmd_t   cmd_reg;
    logic   in_stall_reg;
    logic   out_valid_reg;

    // Sequencer: state, command word and handshake flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        cmd_t cmd_next;
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_IDLE;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_next = CMD_IDLE;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        in_stall_reg <= 1'b1;
                        state_reg    <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    priority if (status.act && status.nr_zero)
                    begin
                        state_reg <= S_PUB;
                    end
                    else if (!status.act || status.nr_one)
                    begin
                        if (status.cnt_zero)
                        begin
                            cmd_next.op = OP_FIRST;
                            state_reg  <= S_PUB;
                        end
                        else
                        begin
                            cmd_next.op = OP_LOAD_WA;
                            state_reg  <= S_W_START;
                        end
                    end
                    else if (status.cnt_one)
                    begin
                        cmd_next.op = OP_LOAD_WS;
                        state_reg  <= S_W_START;
                    end
                    else
                    begin
                        cmd_next.op = OP_LOAD_G;
                        state_reg  <= S_G_M1S;
                    end
                end
                S_W_START:
                begin
                    cmd_next.div_start = 1'b1;
                    cmd_next.div_sel   = DIV_DMAG;
                    state_reg         <= S_W_DIV;
                end
                S_W_DIV:
                begin
                    if (status.div_done)
                    begin
                        cmd_next.op = OP_W_MEAN;
                        state_reg  <= S_W_EMAG;
                    end
                end
                S_W_EMAG:
                begin
                    cmd_next.op = OP_W_EMAG;
                    state_reg  <= S_W_MULS;
                end
                S_W_MULS:
                begin
                    cmd_next.mul_start = 1'b1;
                    cmd_next.mul_sel   = MUL_D_E;
                    state_reg         <= S_W_MUL;
                end
                S_W_MUL:
                begin
                    if (status.mul_done)
                    begin
                        cmd_next.op = OP_W_ADD;
                        state_reg  <= S_W_COMMIT;
                    end
                end
                S_W_COMMIT:
                begin
                    cmd_next.op = OP_W_COMMIT;
                    state_reg  <= S_PUB;
                end
                S_G_M1S:
                begin
                    cmd_next.mul_start = 1'b1;
                    cmd_next.mul_sel   = MUL_D_NR;
                    state_reg         <= S_G_M1;
                end
                S_G_M1:
                begin
                    if (status.mul_done)
                    begin
                        cmd_next.div_start = 1'b1;
                        cmd_next.div_sel   = DIV_PROD;
                        state_reg         <= S_G_D1;
                    end
                end
                S_G_D1:
                begin
                    if (status.div_done)
                    begin
                        cmd_next.op        = OP_G_MEAN;
                        cmd_next.mul_start = 1'b1;
                        cmd_next.mul_sel   = MUL_NL_NR;
                        state_reg         <= S_G_M2;
                    end
                end
                S_G_M2:
                begin
                    if (status.mul_done)
                    begin
                        cmd_next.div_start = 1'b1;
                        cmd_next.div_sel   = DIV_PROD;
                        state_reg         <= S_G_D2;
                    end
                end
                S_G_D2:
                begin
                    if (status.div_done)
                    begin
                        cmd_next.op        = OP_G_QR;
                        cmd_next.mul_start = 1'b1;
                        cmd_next.mul_sel   = MUL_D_D;
                        state_reg         <= S_G_M3;
                    end
                end
                S_G_M3:
                begin
                    // The squared deviation is final here; pick how the cross term is formed.
                    if (status.mul_done)
                    begin
                        priority if (status.qr_zero)
                        begin
                            cmd_next.op = OP_TERM_ZERO;
                            state_reg  <= S_G_ADD1;
                        end
                        else if (status.a_big)
                        begin
                            cmd_next.op = OP_TERM_MAX;
                            state_reg  <= S_G_ADD1;
                        end
                        else
                        begin
                            cmd_next.op = OP_G_A;
                            state_reg  <= S_G_M4S;
                        end
                    end
                end
                S_G_M4S:
                begin
                    cmd_next.mul_start = 1'b1;
                    cmd_next.mul_sel   = MUL_A_Q;
                    state_reg         <= S_G_M4;
                end
                S_G_M4:
                begin
                    if (status.mul_done)
                    begin
                        cmd_next.op = OP_TERM_Q;
                        state_reg  <= S_G_M5S;
                    end
                end
                S_G_M5S:
                begin
                    cmd_next.mul_start = 1'b1;
                    cmd_next.mul_sel   = MUL_A_R;
                    state_reg         <= S_G_M5;
                end
                S_G_M5:
                begin
                    if (status.mul_done)
                    begin
                        cmd_next.div_start = 1'b1;
                        cmd_next.div_sel   = DIV_PROD;
                        state_reg         <= S_G_D3;
                    end
                end
                S_G_D3:
                begin
                    if (status.div_done)
                    begin
                        cmd_next.op = OP_TERM_ADD;
                        state_reg  <= S_G_ADD1;
                    end
                end
                S_G_ADD1:
                begin
                    cmd_next.op = OP_G_ADD1;
                    state_reg  <= S_G_ADD2;
                end
                S_G_ADD2:
                begin
                    cmd_next.op = OP_G_ADD2;
                    state_reg  <= S_PUB;
                end
                S_PUB:
                begin
                    // Wait until the result register is free or is being emptied now.
                    if (!out_valid_reg || !out_stall)
                    begin
                        cmd_next.op = OP_PUBLISH;
                        state_reg  <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    out_valid_reg <= 1'b1;
                    in_stall_reg  <= 1'b0;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            cmd_reg <= cmd_next;
        end
    end

    assign cmd       = cmd_reg;
    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

    // The input side is open only while the sequencer is idle.
    a_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall_reg |-> (state_reg == S_IDLE))
        else $error("input open outside idle");

    // The shared units are never started in the same cycle.
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_reg.mul_start && cmd_reg.div_start))
        else $error("multiplier and divider started together");

    // A result is only loaded into an empty result register.
    a_pub_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_reg.op == OP_PUBLISH) |-> !out_valid_reg)
        else $error("result register overwritten");

    // Every loaded result is offered in the next cycle.
    a_pub_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_reg.op == OP_PUBLISH) |=> out_valid_reg)
        else $error("published result not offered");

endmodule

FILE: hdl/running_mean_variance_accumulator.sv
// Work per item: an append, or a merge of a one-sample summary or into a one-sample count,
// runs one divide and one multiply; a general merge runs three divides and five multiplies
// (two and three into a count of zero or with a saturated cross term); a first sample or an
// empty summary uses neither unit. The pace is set by the 96-step restoring divider and the
// 33-step shift-add multiplier; one item at a time, in_stall high until the result is offered.
// Reset (rst_n, asynchronous, active low) clears count, mean, M2 and the overflow flag.
`timescale 1ns / 1ps

module running_mean_variance_accumulator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         action,
    input  logic [rmva_pkg::DATA_W-1:0]  sample,
    input  logic [rmva_pkg::DATA_W-1:0]  part_mean,
    input  logic [rmva_pkg::M2_W-1:0]    part_m2,
    input  logic [rmva_pkg::COUNT_W-1:0] part_count,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [rmva_pkg::COUNT_W-1:0] total_count,
    output logic [rmva_pkg::DATA_W-1:0]  running_mean,
    output logic [rmva_pkg::M2_W-1:0]    running_m2,
    output logic                         overflow
);
    import rmva_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    take;

    // An item is taken when offered while the input side is open.
    assign take = in_valid && !in_stall;

    rmva_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    rmva_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .action       (action),
        .sample       (sample),
        .part_mean    (part_mean),
        .part_m2      (part_m2),
        .part_count   (part_count),
        .cmd          (cmd),
        .status       (status),
        .total_count  (total_count),
        .running_mean (running_mean),
        .running_m2   (running_m2),
        .overflow     (overflow)
    );

endmodule
